[rtl/tsrq_pkg.sv]
package tsrq_pkg;

   // command codes carried on req_tuser
   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_LOCK   = 2'd1;
   localparam logic [1:0] CMD_TAKE   = 2'd2;
   localparam logic [1:0] CMD_UNLOCK = 2'd3;

   localparam logic [7:0] LOCK_MAX = 8'd255;

   typedef enum logic [1:0] {
      OP_INSERT,
      OP_LOCK,
      OP_TAKE,
      OP_UNLOCK
   } op_type;

   // decoded command passed from the front to the back
   typedef struct packed {
      op_type      op;
      logic [15:0] id;
      logic [63:0] stamp;
      logic [4:0]  count;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_LCK_RD,
      ST_LCK_MOD,
      ST_TAK_RD,
      ST_TAK_CHK,
      ST_UNL_RD,
      ST_UNL_CMP,
      ST_FAIL
   } back_state_type;

endpackage

[rtl/tsrq_front.sv]
module tsrq_front
   import tsrq_pkg::*;
#(
   parameter int ID_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [87:0] req_tdata,   // frame_id, frame_time, lock_count, zero pad
   input  logic [1:0]  req_tuser,   // cmd
   output logic        cmd_valid,
   input  logic        cmd_ready,
   output cmd_type     cmd_data
);

   localparam int KEEP = (ID_BITS < 16) ? ID_BITS : 16;
   localparam logic [15:0] ID_MASK = 16'((17'(1) << KEEP) - 17'(1));

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;
   cmd_type    decoded;

   assign req_tready = (count_ff != 2'd2);
   assign cmd_valid  = (count_ff != 2'd0);
   assign cmd_data   = slot_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = cmd_valid && cmd_ready;

   always_comb begin
      decoded.id    = req_tdata[15:0] & ID_MASK;
      decoded.stamp = req_tdata[79:16];
      decoded.count = req_tdata[84:80];
      unique case (req_tuser)
         CMD_INSERT: decoded.op = OP_INSERT;
         CMD_LOCK:   decoded.op = OP_LOCK;
         CMD_TAKE:   decoded.op = OP_TAKE;
         default:    decoded.op = OP_UNLOCK;
      endcase
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

[rtl/tsrq_engine.sv]
module tsrq_engine
   import tsrq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_BITS     = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   output logic        cmd_ready,
   input  cmd_type     cmd_data,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // result_id, occupancy, zero pad
   output logic        rsp_tuser,   // ok
   output logic        rsp_tlast
);

   localparam int AW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW   = $clog2(QUEUE_DEPTH + 1);
   localparam int KEEP = (ID_BITS < 16) ? ID_BITS : 16;
   localparam int NW   = (CW > 5) ? CW : 5;

   // entry store, newest at address 0
   logic [KEEP-1:0] ids_mem   [QUEUE_DEPTH];
   logic [63:0]     times_mem [QUEUE_DEPTH];
   logic [7:0]      locks_mem [QUEUE_DEPTH];

   back_state_type state_ff, state_in;
   logic [CW-1:0]  fill_ff, fill_in;
   logic [CW-1:0]  idx_ff, idx_in;
   logic [CW-1:0]  n_ff, n_in;
   cmd_type        cur_ff, cur_in;

   logic [KEEP-1:0] rd_id_ff;
   logic [63:0]     rd_time_ff;
   logic [7:0]      rd_lock_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_id_ff, rsp_id_in;
   logic        rsp_ok_ff, rsp_ok_in;
   logic        rsp_last_ff, rsp_last_in;
   logic [4:0]  rsp_occ_ff, rsp_occ_in;

   logic            mem_we, mem_re;
   logic [AW-1:0]   mem_waddr, mem_raddr;
   logic [KEEP-1:0] mem_wid;
   logic [63:0]     mem_wtime;
   logic [7:0]      mem_wlock;

   logic          out_free, is_full, shift_down, lock_last, unl_hit;
   logic [CW-1:0] idx_m1, fill_m1, fill_p1, idx_p1, lock_n;
   logic [NW-1:0] cnt_ext, fill_ext;
   logic [7:0]    lock_inc;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign is_full    = (fill_ff == CW'(QUEUE_DEPTH));
   assign idx_m1     = idx_ff - CW'(1);
   assign idx_p1     = idx_ff + CW'(1);
   assign fill_m1    = fill_ff - CW'(1);
   assign fill_p1    = fill_ff + CW'(1);
   assign shift_down = (rd_time_ff < cur_ff.stamp);
   assign lock_last  = (idx_p1 == n_ff);
   assign unl_hit    = (rd_id_ff == cur_ff.id[KEEP-1:0]) && (rd_lock_ff != 8'd0);
   assign lock_inc   = (rd_lock_ff == LOCK_MAX) ? rd_lock_ff : rd_lock_ff + 8'd1;
   assign cnt_ext    = NW'(cmd_data.count);
   assign fill_ext   = NW'(fill_ff);
   assign lock_n     = (cnt_ext < fill_ext) ? CW'(cnt_ext) : fill_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_occ_ff, rsp_id_ff};
   assign rsp_tuser  = rsp_ok_ff;
   assign rsp_tlast  = rsp_last_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd_data.op)
                  OP_INSERT: state_in = is_full ? ST_FAIL : ST_INS_RD;
                  OP_LOCK:   state_in = (lock_n == '0) ? ST_FAIL : ST_LCK_RD;
                  OP_TAKE:   state_in = (fill_ff == '0) ? ST_FAIL : ST_TAK_RD;
                  default:   state_in = ST_UNL_RD;
               endcase
            end
         end
         ST_INS_RD: begin
            if (idx_ff != '0) begin
               state_in = ST_INS_CMP;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_INS_CMP: begin
            if (shift_down) begin
               state_in = ST_INS_RD;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_LCK_RD:  state_in = ST_LCK_MOD;
         ST_LCK_MOD: begin
            if (out_free) begin
               state_in = lock_last ? ST_IDLE : ST_LCK_RD;
            end
         end
         ST_TAK_RD:  state_in = ST_TAK_CHK;
         ST_TAK_CHK: state_in = out_free ? ST_IDLE : ST_TAK_CHK;
         ST_UNL_RD:  state_in = (idx_ff == fill_ff) ? ST_FAIL : ST_UNL_CMP;
         ST_UNL_CMP: begin
            if (!unl_hit) begin
               state_in = ST_UNL_RD;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_FAIL:    state_in = out_free ? ST_IDLE : ST_FAIL;
         default:    state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      n_in         = n_ff;
      cur_in       = cur_ff;
      cmd_ready    = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = idx_ff[AW-1:0];
      mem_wid      = cur_ff.id[KEEP-1:0];
      mem_wtime    = cur_ff.stamp;
      mem_wlock    = 8'd0;
      mem_re       = 1'b0;
      mem_raddr    = idx_ff[AW-1:0];
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_id_in    = rsp_id_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_occ_in   = rsp_occ_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               cur_in = cmd_data;
               n_in   = lock_n;
               idx_in = (cmd_data.op == OP_INSERT) ? fill_ff : '0;
            end
         end
         ST_INS_RD: begin
            if (idx_ff != '0) begin
               mem_re    = 1'b1;
               mem_raddr = idx_m1[AW-1:0];
            end else if (out_free) begin
               mem_we       = 1'b1;
               fill_in      = fill_p1;
               rsp_valid_in = 1'b1;
               rsp_id_in    = 16'd0;
               rsp_ok_in    = 1'b1;
               rsp_last_in  = 1'b1;
               rsp_occ_in   = 5'(fill_p1);
            end
         end
         ST_INS_CMP: begin
            if (shift_down) begin
               // move the older entry one place toward the tail
               mem_we    = 1'b1;
               mem_wid   = rd_id_ff;
               mem_wtime = rd_time_ff;
               mem_wlock = rd_lock_ff;
               idx_in    = idx_m1;
            end else if (out_free) begin
               mem_we       = 1'b1;
               fill_in      = fill_p1;
               rsp_valid_in = 1'b1;
               rsp_id_in    = 16'd0;
               rsp_ok_in    = 1'b1;
               rsp_last_in  = 1'b1;
               rsp_occ_in   = 5'(fill_p1);
            end
         end
         ST_LCK_RD: begin
            mem_re = 1'b1;
         end
         ST_LCK_MOD: begin
            if (out_free) begin
               mem_we       = 1'b1;
               mem_wid      = rd_id_ff;
               mem_wtime    = rd_time_ff;
               mem_wlock    = lock_inc;
               idx_in       = idx_p1;
               rsp_valid_in = 1'b1;
               rsp_id_in    = 16'(rd_id_ff);
               rsp_ok_in    = 1'b1;
               rsp_last_in  = lock_last;
               rsp_occ_in   = 5'(fill_ff);
            end
         end
         ST_TAK_RD: begin
            mem_re    = 1'b1;
            mem_raddr = fill_m1[AW-1:0];
         end
         ST_TAK_CHK: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               if (rd_lock_ff != 8'd0) begin
                  rsp_id_in  = 16'd0;
                  rsp_ok_in  = 1'b0;
                  rsp_occ_in = 5'(fill_ff);
               end else begin
                  fill_in    = fill_m1;
                  rsp_id_in  = 16'(rd_id_ff);
                  rsp_ok_in  = 1'b1;
                  rsp_occ_in = 5'(fill_m1);
               end
            end
         end
         ST_UNL_RD: begin
            mem_re = (idx_ff != fill_ff);
         end
         ST_UNL_CMP: begin
            if (!unl_hit) begin
               idx_in = idx_p1;
            end else if (out_free) begin
               mem_we       = 1'b1;
               mem_wid      = rd_id_ff;
               mem_wtime    = rd_time_ff;
               mem_wlock    = rd_lock_ff - 8'd1;
               rsp_valid_in = 1'b1;
               rsp_id_in    = 16'd0;
               rsp_ok_in    = 1'b1;
               rsp_last_in  = 1'b1;
               rsp_occ_in   = 5'(fill_ff);
            end
         end
         ST_FAIL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = 16'd0;
               rsp_ok_in    = 1'b0;
               rsp_last_in  = 1'b1;
               rsp_occ_in   = 5'(fill_ff);
            end
         end
         default: begin
            cmd_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      n_ff        <= n_in;
      cur_ff      <= cur_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_last_ff <= rsp_last_in;
      rsp_occ_ff  <= rsp_occ_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ids_mem[mem_waddr]   <= mem_wid;
         times_mem[mem_waddr] <= mem_wtime;
         locks_mem[mem_waddr] <= mem_wlock;
      end
      if (mem_re) begin
         rd_id_ff   <= ids_mem[mem_raddr];
         rd_time_ff <= times_mem[mem_raddr];
         rd_lock_ff <= locks_mem[mem_raddr];
      end
   end

endmodule

[rtl/time_sorted_refcount_queue.sv]
// Time-sorted frame queue with lock counts.
// req channel: one word per command. req_tuser carries the command (insert,
// lock newest, take oldest, unlock); req_tdata carries frame_id, frame_time
// and lock_count. rsp channel: one word per result, rsp_tuser is the ok flag,
// rsp_tlast marks the final result of a command, rsp_tdata carries result_id
// and occupancy. Lock newest gives one result per locked entry.
// A two-word command queue decouples intake from execution, so req_tready
// stays high until two commands wait behind the one in progress.
// Steps of each command once it leaves the queue:
//   insert       move each older entry one place down, from the tail, while
//                it is older than the new one, then write the new entry
//   lock newest  read each locked entry and raise its lock count
//   take oldest  read the oldest entry; remove it if its lock count is zero
//   unlock       scan from the newest for the id with a nonzero count, lower it
//   failures that need no memory access go straight to the failed result.
// The entry memory has a registered read, so each entry is read before it is used.
// Reset empties the queue and drops any pending command or result; entry
// contents are not cleared. When the receiver holds rsp_tready low the
// result word holds and the engine waits; commands still queue up to two.
module time_sorted_refcount_queue
   import tsrq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_BITS     = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [87:0] req_tdata,   // [15:0] frame_id, [79:16] frame_time,
                                    // [84:80] lock_count, [87:85] zero
   input  logic [1:0]  req_tuser,   // [1:0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [15:0] result_id, [20:16] occupancy,
                                    // [23:21] zero
   output logic        rsp_tuser,   // [0] ok
   output logic        rsp_tlast    // last result of the command
);

   logic    cmd_valid;
   logic    cmd_ready;
   cmd_type cmd_data;

   // intake: decode the command and mask the id, then queue it
   tsrq_front #(
      .ID_BITS (ID_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd_data   (cmd_data)
   );

   // execution: walk the entry memory and drive the result register
   tsrq_engine #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ID_BITS     (ID_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd_data   (cmd_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[rtl/tsrq_checker.sv]
module tsrq_checker #(
   parameter int QUEUE_DEPTH = 16
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   localparam logic [5:0] OCC_MAX = 6'((QUEUE_DEPTH < 32) ? QUEUE_DEPTH : 31);

   // hold a stalled result word
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         ($stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast)))
      else $error("rsp word changed while stalled");

   // a failed result carries id zero and closes its command
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[15:0] == 16'd0) && rsp_tlast)
      else $error("failed result with nonzero id or not last");

   // occupancy never exceeds the depth
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (QUEUE_DEPTH < 32)) |-> ({1'b0, rsp_tdata[20:16]} <= OCC_MAX))
      else $error("occupancy above queue depth");

   // nothing is shown right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind time_sorted_refcount_queue tsrq_checker #(
   .QUEUE_DEPTH (QUEUE_DEPTH)
) u_tsrq_checker (.*);
